@@ hdl/etsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package etsp_pkg;

	localparam int DUTY_W     = 14;
	localparam int MS_W       = 16;
	localparam int CMD_W      = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int SPEED_LIMIT_DEF = 100;
	localparam int STEER_LIMIT_DEF = 200;

	localparam logic ACT_DRIVE = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SPEED_DUTY_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_DUTY_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEER_DUTY_LEFT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEER_DUTY_RIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_DUTY     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DUTY     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ARM_TIMEOUT      = 3'd6;

	localparam logic [DUTY_W-1:0] SPEED_DUTY_LOW_RST   = 14'd700;
	localparam logic [DUTY_W-1:0] SPEED_DUTY_HIGH_RST  = 14'd950;
	localparam logic [DUTY_W-1:0] STEER_DUTY_LEFT_RST  = 14'd1155;
	localparam logic [DUTY_W-1:0] STEER_DUTY_RIGHT_RST = 14'd650;
	localparam logic [DUTY_W-1:0] NEUTRAL_DUTY_RST     = 14'd890;
	localparam logic [DUTY_W-1:0] REVERSE_DUTY_RST     = 14'd850;
	localparam logic [MS_W-1:0]   ARM_TIMEOUT_RST      = 16'd3000;

	typedef struct packed {
		logic ld2;
		logic ld3;
		logic ld4;
	} etsp_stage_en_t;

endpackage

`default_nettype wire

@@ hdl/etsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface etsp_item_if;
	import etsp_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    action;
	logic signed [CMD_W-1:0] speed_cmd;
	logic signed [CMD_W-1:0] steer_cmd;
	logic [MS_W-1:0]         elapsed_ms;

	modport source (output valid, action, speed_cmd, steer_cmd, elapsed_ms, input ready);
	modport sink (input valid, action, speed_cmd, steer_cmd, elapsed_ms, output ready);
endinterface

interface etsp_result_if;
	import etsp_pkg::*;
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] speed_duty;
	logic [DUTY_W-1:0] steer_duty;
	logic              armed;
	logic              moving_forward;
	logic              accepted;

	modport source (output valid, speed_duty, steer_duty, armed, moving_forward, accepted,
		input ready);
	modport sink (input valid, speed_duty, steer_duty, armed, moving_forward, accepted,
		output ready);
endinterface

interface etsp_cfg_if;
	import etsp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/etsp_map_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

module etsp_map_lane #(
	parameter int LIMIT = etsp_pkg::SPEED_LIMIT_DEF,
	localparam int KW = $clog2(2 * LIMIT + 1)
) (
	input  wire                          clk,
	input  wire etsp_pkg::etsp_stage_en_t en,
	input  wire  [KW-1:0]                k,
	input  wire  [etsp_pkg::DUTY_W-1:0]  lo,
	input  wire  [etsp_pkg::DUTY_W-1:0]  hi,
	output logic [etsp_pkg::DUTY_W-1:0]  duty_s4
);
	import etsp_pkg::*;

	localparam int DEN  = 2 * LIMIT;
	localparam int NUMW = KW + DUTY_W;
	localparam int SH   = NUMW;
	localparam int PW   = NUMW + SH;
	localparam longint unsigned RECIP = (64'd1 << SH) / DEN;
	localparam logic [SH-1:0] RECIP_V = SH'(RECIP);
	localparam logic [NUMW-1:0] DEN_V = NUMW'(DEN);

	logic signed [DUTY_W:0] diff;
	logic [DUTY_W-1:0]      adiff;
	logic [PW-1:0]          prod;
	logic [NUMW-1:0]        rem;
	logic                   carry;
	logic                   rnd;
	logic [DUTY_W:0]        qmag;
	logic [DUTY_W:0]        dfull;

	logic [NUMW-1:0]   num_s2, num_s3;
	logic              neg_s2, neg_s3;
	logic [DUTY_W-1:0] lo_s2, lo_s3;
	logic [DUTY_W-1:0] qe_s3;

	// |hi - lo| times offset; sign kept aside for floor of negatives
	always_comb begin
		diff  = $signed({1'b0, hi}) - $signed({1'b0, lo});
		adiff = diff[DUTY_W] ? DUTY_W'(-diff) : diff[DUTY_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en.ld2) begin
			num_s2 <= NUMW'(k) * NUMW'(adiff);
			neg_s2 <= diff[DUTY_W];
			lo_s2  <= lo;
		end
	end

	// reciprocal estimate, low by at most one
	assign prod = PW'(num_s2) * PW'(RECIP_V);

	always_ff @(posedge clk) begin
		if (en.ld3) begin
			qe_s3  <= prod[SH +: DUTY_W];
			num_s3 <= num_s2;
			neg_s3 <= neg_s2;
			lo_s3  <= lo_s2;
		end
	end

	always_comb begin
		rem   = num_s3 - NUMW'(qe_s3) * DEN_V;
		carry = rem >= DEN_V;
		rnd   = neg_s3 && (rem != '0) && (rem != DEN_V);
		qmag  = {1'b0, qe_s3} + (DUTY_W+1)'(carry) + (DUTY_W+1)'(rnd);
		dfull = neg_s3 ? ({1'b0, lo_s3} - qmag) : ({1'b0, lo_s3} + qmag);
	end

	always_ff @(posedge clk) begin
		if (en.ld4) begin
			duty_s4 <= dfull[DUTY_W-1:0];
		end
	end

endmodule

`default_nettype wire

@@ hdl/esc_throttle_steer_pwm_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel | dir  | payload
// item    | in   | action, speed_cmd, steer_cmd, elapsed_ms
// result  | out  | speed_duty, steer_duty, armed, moving_forward, accepted
// cfg     | in   | index, data (always ready)
//
// One word accepted per cycle unless a stalled result backs up; results pass s1 to s4, then the output register.
// Stages set by the mapping lanes: product, reciprocal multiply, correction.
// State and result register update together in the last stage, in order.
// Reset clears stage valids and state, and sets config registers to their defaults.
// A stalled result backs up through the stage valids; bubbles still fill.

module esc_throttle_steer_pwm_sequencer #(
	parameter int SPEED_LIMIT = etsp_pkg::SPEED_LIMIT_DEF,
	parameter int STEER_LIMIT = etsp_pkg::STEER_LIMIT_DEF
) (
	input wire            clk,
	input wire            arst_n,
	etsp_item_if.sink     item,
	etsp_result_if.source result,
	etsp_cfg_if.sink      cfg
);
	import etsp_pkg::*;

	localparam int SP_KW = $clog2(2 * SPEED_LIMIT + 1);
	localparam int ST_KW = $clog2(2 * STEER_LIMIT + 1);
	localparam logic signed [CMD_W:0] SP_LIM = (CMD_W+1)'(SPEED_LIMIT);
	localparam logic signed [CMD_W:0] ST_LIM = (CMD_W+1)'(STEER_LIMIT);

	logic [DUTY_W-1:0] speed_duty_low_q, speed_duty_high_q;
	logic [DUTY_W-1:0] steer_duty_left_q, steer_duty_right_q;
	logic [DUTY_W-1:0] neutral_duty_q, reverse_duty_q;
	logic [MS_W-1:0]   arm_timeout_q;

	logic [DUTY_W-1:0] stored_speed_q, stored_steer_q, throttle_q, steer_out_q;
	logic              arm_started_q, forward_q;
	logic [MS_W-1:0]   arm_elapsed_q;

	logic v1_s1, v2_s2, v3_s3, v4_s4, vo_q;
	logic r1, r2, r3, r4, rdy_o, fire;
	etsp_stage_en_t en;

	logic                    act_s1, act_s2, act_s3, act_s4;
	logic signed [CMD_W-1:0] sp_s1, st_s1;
	logic [MS_W-1:0]         el_s1, el_s2, el_s3, el_s4;
	logic                    ok_s2, ok_s3, ok_s4;

	logic signed [CMD_W:0] sp13, st13, spk_full, stk_full;
	logic                  in_range;
	logic [DUTY_W-1:0]     sp_duty_s4, st_duty_s4;

	logic [DUTY_W-1:0] n_stored_speed, n_stored_steer, n_throttle, n_steer_out;
	logic              n_started, n_forward;
	logic [MS_W-1:0]   n_elapsed;
	logic [MS_W:0]     el_sum;

	logic [DUTY_W-1:0] speed_duty_q, steer_duty_q;
	logic              armed_q, moving_forward_q, accepted_q;

	// handshake chain
	assign rdy_o  = !vo_q || result.ready;
	assign r4     = !v4_s4 || rdy_o;
	assign r3     = !v3_s3 || r4;
	assign r2     = !v2_s2 || r3;
	assign r1     = !v1_s1 || r2;
	assign fire   = v4_s4 && rdy_o;
	assign en.ld2 = v1_s1 && r2;
	assign en.ld3 = v2_s2 && r3;
	assign en.ld4 = v3_s3 && r4;

	assign item.ready = r1;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			vo_q  <= 1'b0;
		end else begin
			if (r1) v1_s1 <= item.valid;
			if (r2) v2_s2 <= v1_s1;
			if (r3) v3_s3 <= v2_s2;
			if (r4) v4_s4 <= v3_s3;
			if (rdy_o) vo_q <= v4_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_duty_low_q   <= SPEED_DUTY_LOW_RST;
			speed_duty_high_q  <= SPEED_DUTY_HIGH_RST;
			steer_duty_left_q  <= STEER_DUTY_LEFT_RST;
			steer_duty_right_q <= STEER_DUTY_RIGHT_RST;
			neutral_duty_q     <= NEUTRAL_DUTY_RST;
			reverse_duty_q     <= REVERSE_DUTY_RST;
			arm_timeout_q      <= ARM_TIMEOUT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SPEED_DUTY_LOW:   speed_duty_low_q   <= cfg.data[DUTY_W-1:0];
				REG_SPEED_DUTY_HIGH:  speed_duty_high_q  <= cfg.data[DUTY_W-1:0];
				REG_STEER_DUTY_LEFT:  steer_duty_left_q  <= cfg.data[DUTY_W-1:0];
				REG_STEER_DUTY_RIGHT: steer_duty_right_q <= cfg.data[DUTY_W-1:0];
				REG_NEUTRAL_DUTY:     neutral_duty_q     <= cfg.data[DUTY_W-1:0];
				REG_REVERSE_DUTY:     reverse_duty_q     <= cfg.data[DUTY_W-1:0];
				REG_ARM_TIMEOUT:      arm_timeout_q      <= cfg.data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (r1 && item.valid) begin
			act_s1 <= item.action;
			sp_s1  <= item.speed_cmd;
			st_s1  <= item.steer_cmd;
			el_s1  <= item.elapsed_ms;
		end
	end

	always_comb begin
		sp13     = {sp_s1[CMD_W-1], sp_s1};
		st13     = {st_s1[CMD_W-1], st_s1};
		in_range = (sp13 >= -SP_LIM) && (sp13 <= SP_LIM) &&
		           (st13 >= -ST_LIM) && (st13 <= ST_LIM);
		spk_full = sp13 + SP_LIM;
		stk_full = st13 + ST_LIM;
	end

	always_ff @(posedge clk) begin
		if (en.ld2) begin
			act_s2 <= act_s1;
			el_s2  <= el_s1;
			ok_s2  <= in_range;
		end
		if (en.ld3) begin
			act_s3 <= act_s2;
			el_s3  <= el_s2;
			ok_s3  <= ok_s2;
		end
		if (en.ld4) begin
			act_s4 <= act_s3;
			el_s4  <= el_s3;
			ok_s4  <= ok_s3;
		end
	end

	// lanes take their inputs from the stage-one registers, alongside the range check
	etsp_map_lane #(.LIMIT(SPEED_LIMIT)) u_speed_lane (
		.clk     (clk),
		.en      (en),
		.k       (spk_full[SP_KW-1:0]),
		.lo      (speed_duty_low_q),
		.hi      (speed_duty_high_q),
		.duty_s4 (sp_duty_s4)
	);

	etsp_map_lane #(.LIMIT(STEER_LIMIT)) u_steer_lane (
		.clk     (clk),
		.en      (en),
		.k       (stk_full[ST_KW-1:0]),
		.lo      (steer_duty_left_q),
		.hi      (steer_duty_right_q),
		.duty_s4 (st_duty_s4)
	);

	always_comb begin
		n_stored_speed = stored_speed_q;
		n_stored_steer = stored_steer_q;
		n_throttle     = throttle_q;
		n_steer_out    = steer_out_q;
		n_started      = arm_started_q;
		n_elapsed      = arm_elapsed_q;
		n_forward      = forward_q;
		el_sum         = {1'b0, arm_elapsed_q} + {1'b0, el_s4};
		if (act_s4 == ACT_DRIVE) begin
			if (ok_s4) begin
				n_stored_speed = sp_duty_s4;
				n_stored_steer = st_duty_s4;
			end
		end else begin
			if (!arm_started_q) begin
				n_throttle = neutral_duty_q;
				n_started  = 1'b1;
				n_elapsed  = '0;
			end else begin
				n_elapsed = el_sum[MS_W] ? {MS_W{1'b1}} : el_sum[MS_W-1:0];
				if (n_elapsed >= arm_timeout_q) begin
					priority if (stored_speed_q == neutral_duty_q) begin
						n_throttle = neutral_duty_q;
					end else if (forward_q && stored_speed_q < reverse_duty_q) begin
						n_throttle = neutral_duty_q;
						n_forward  = 1'b0;
					end else if (stored_speed_q > neutral_duty_q) begin
						n_throttle = stored_speed_q;
						n_forward  = 1'b1;
					end else begin
						n_throttle = stored_speed_q;
					end
				end
			end
			n_steer_out = stored_steer_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_speed_q <= '0;
			stored_steer_q <= '0;
			throttle_q     <= '0;
			steer_out_q    <= '0;
			arm_started_q  <= 1'b0;
			arm_elapsed_q  <= '0;
			forward_q      <= 1'b0;
		end else if (fire) begin
			stored_speed_q <= n_stored_speed;
			stored_steer_q <= n_stored_steer;
			throttle_q     <= n_throttle;
			steer_out_q    <= n_steer_out;
			arm_started_q  <= n_started;
			arm_elapsed_q  <= n_elapsed;
			forward_q      <= n_forward;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			speed_duty_q     <= n_throttle;
			steer_duty_q     <= n_steer_out;
			armed_q          <= n_started && (n_elapsed >= arm_timeout_q);
			moving_forward_q <= n_forward;
			accepted_q       <= (act_s4 == ACT_DRIVE) && ok_s4;
		end
	end

	assign result.valid          = vo_q;
	assign result.speed_duty     = speed_duty_q;
	assign result.steer_duty     = steer_duty_q;
	assign result.armed          = armed_q;
	assign result.moving_forward = moving_forward_q;
	assign result.accepted       = accepted_q;

	a_fwd_needs_arm: assert property (@(posedge clk) disable iff (!arst_n)
		forward_q |-> arm_started_q)
		else $error("forward set before arming started");

	a_thr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!arm_started_q |-> throttle_q == '0)
		else $error("throttle driven before first tick");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v4_s4 && !rdy_o |=> v4_s4)
		else $error("last stage word lost under stall");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> v1_s1)
		else $error("accepted word not in first stage");

endmodule

`default_nettype wire

@@ sim/tb_esc_throttle_steer_pwm_sequencer.sv @@
`timescale 1ns / 1ps

module tb_esc_throttle_steer_pwm_sequencer;
	import etsp_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_WORDS = 240;
	localparam int LONG_HOLD   = 120;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic                    action;
		logic signed [CMD_W-1:0] speed_cmd;
		logic signed [CMD_W-1:0] steer_cmd;
		logic [MS_W-1:0]         elapsed_ms;
	} drive_word_t;

	typedef struct {
		logic [DUTY_W-1:0] speed_duty;
		logic [DUTY_W-1:0] steer_duty;
		logic              armed;
		logic              moving_forward;
		logic              accepted;
	} duty_word_t;

	class duty_scoreboard;
		bit [DUTY_W-1:0] spd_lo, spd_hi, str_left, str_right, neutral, rev_thr;
		bit [MS_W-1:0]   arm_timeout;
		bit [DUTY_W-1:0] stored_spd, stored_str, throttle, steer_o;
		bit              arm_on, fwd;
		bit [MS_W-1:0]   arm_ms;
		duty_word_t      duty_queue[$];
		int              errors;

		function new();
			spd_lo      = SPEED_DUTY_LOW_RST;
			spd_hi      = SPEED_DUTY_HIGH_RST;
			str_left    = STEER_DUTY_LEFT_RST;
			str_right   = STEER_DUTY_RIGHT_RST;
			neutral     = NEUTRAL_DUTY_RST;
			rev_thr     = REVERSE_DUTY_RST;
			arm_timeout = ARM_TIMEOUT_RST;
			stored_spd  = '0;
			stored_str  = '0;
			throttle    = '0;
			steer_o     = '0;
			arm_on      = 1'b0;
			fwd         = 1'b0;
			arm_ms      = '0;
			errors      = 0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_SPEED_DUTY_LOW:   spd_lo = data[DUTY_W-1:0];
			REG_SPEED_DUTY_HIGH:  spd_hi = data[DUTY_W-1:0];
			REG_STEER_DUTY_LEFT:  str_left = data[DUTY_W-1:0];
			REG_STEER_DUTY_RIGHT: str_right = data[DUTY_W-1:0];
			REG_NEUTRAL_DUTY:     neutral = data[DUTY_W-1:0];
			REG_REVERSE_DUTY:     rev_thr = data[DUTY_W-1:0];
			REG_ARM_TIMEOUT:      arm_timeout = data[MS_W-1:0];
			default: ;
			endcase
		endfunction

		// linear map, floored
		function bit [DUTY_W-1:0] map_duty(input int cmd, input int lim,
				input bit [DUTY_W-1:0] lo, input bit [DUTY_W-1:0] hi);
			longint num, den, q, res;
			num = longint'(cmd + lim) * (longint'(hi) - longint'(lo));
			den = 2 * longint'(lim);
			if (num >= 0) begin
				q = num / den;
			end else begin
				q = -((-num + den - 1) / den);
			end
			res = longint'(lo) + q;
			return res[DUTY_W-1:0];
		endfunction

		function duty_word_t next_duties(input drive_word_t w);
			duty_word_t d;
			int sp, st, total;
			bit acc;
			acc = 1'b0;
			if (w.action == ACT_DRIVE) begin
				sp = w.speed_cmd;
				st = w.steer_cmd;
				if (sp >= -SPEED_LIMIT_DEF && sp <= SPEED_LIMIT_DEF &&
						st >= -STEER_LIMIT_DEF && st <= STEER_LIMIT_DEF) begin
					stored_spd = map_duty(sp, SPEED_LIMIT_DEF, spd_lo, spd_hi);
					stored_str = map_duty(st, STEER_LIMIT_DEF, str_left, str_right);
					acc = 1'b1;
				end
			end else begin
				if (!arm_on) begin
					throttle = neutral;
					arm_on = 1'b1;
					arm_ms = '0;
				end else begin
					total = int'(arm_ms) + int'(w.elapsed_ms);
					arm_ms = (total > 65535) ? 16'hFFFF : total[MS_W-1:0];
					if (arm_ms >= arm_timeout) begin
						if (stored_spd == neutral) begin
							throttle = neutral;
						end else if (fwd && stored_spd < rev_thr) begin
							throttle = neutral;
							fwd = 1'b0;
						end else if (stored_spd > neutral) begin
							throttle = stored_spd;
							fwd = 1'b1;
						end else begin
							throttle = stored_spd;
						end
					end
				end
				steer_o = stored_str;
			end
			d.speed_duty     = throttle;
			d.steer_duty     = steer_o;
			d.armed          = arm_on && (arm_ms >= arm_timeout);
			d.moving_forward = fwd;
			d.accepted       = acc;
			return d;
		endfunction

		function void note_item(input drive_word_t w);
			duty_queue.push_back(next_duties(w));
		endfunction

		function void check_word(input duty_word_t got);
			duty_word_t exp_d;
			if (duty_queue.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: result word with nothing expected: duty %0d steer %0d",
						got.speed_duty, got.steer_duty);
				return;
			end
			exp_d = duty_queue.pop_front();
			if (got.speed_duty !== exp_d.speed_duty || got.steer_duty !== exp_d.steer_duty ||
					got.armed !== exp_d.armed || got.moving_forward !== exp_d.moving_forward ||
					got.accepted !== exp_d.accepted) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: exp %0d/%0d/%0b/%0b/%0b got %0d/%0d/%0b/%0b/%0b",
						exp_d.speed_duty, exp_d.steer_duty, exp_d.armed,
						exp_d.moving_forward, exp_d.accepted,
						got.speed_duty, got.steer_duty, got.armed,
						got.moving_forward, got.accepted);
			end
		endfunction

		function int pending();
			return duty_queue.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	etsp_item_if   item_ch ();
	etsp_result_if res_ch ();
	etsp_cfg_if    cfg_ch ();

	esc_throttle_steer_pwm_sequencer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	duty_scoreboard sb = new();

	bit idle_on = 1'b1;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int gap_left = 0;
	int cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: random stalls plus a long hold-off on request
	initial begin
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				res_ch.ready <= 1'b0;
			end else if (idle_on && !quiet && $urandom_range(0, 4) == 0) begin
				gap_left = $urandom_range(1, 5) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		duty_word_t got;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got.speed_duty     = res_ch.speed_duty;
			got.steer_duty     = res_ch.steer_duty;
			got.armed          = res_ch.armed;
			got.moving_forward = res_ch.moving_forward;
			got.accepted       = res_ch.accepted;
			sb.check_word(got);
		end
	end

	task automatic send_word(input drive_word_t w);
		if (idle_on && !quiet && $urandom_range(0, 4) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.action     <= w.action;
		item_ch.speed_cmd  <= w.speed_cmd;
		item_ch.steer_cmd  <= w.steer_cmd;
		item_ch.elapsed_ms <= w.elapsed_ms;
		@(posedge clk);
		while (item_ch.ready !== 1'b1) @(posedge clk);
		sb.note_item(w);
	endtask

	task automatic send_drive(input int sp, input int st);
		drive_word_t w;
		w.action     = ACT_DRIVE;
		w.speed_cmd  = CMD_W'(sp);
		w.steer_cmd  = CMD_W'(st);
		w.elapsed_ms = MS_W'($urandom);
		send_word(w);
	endtask

	task automatic send_tick(input int ms);
		drive_word_t w;
		w.action     = ACT_TICK;
		w.speed_cmd  = CMD_W'($urandom);
		w.steer_cmd  = CMD_W'($urandom);
		w.elapsed_ms = MS_W'(ms);
		send_word(w);
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1) @(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic load_config(input int lo, input int hi, input int left, input int right,
			input int neu, input int rev, input int tmo);
		write_reg(REG_SPEED_DUTY_LOW, CFG_DATA_W'(lo));
		write_reg(REG_SPEED_DUTY_HIGH, CFG_DATA_W'(hi));
		write_reg(REG_STEER_DUTY_LEFT, CFG_DATA_W'(left));
		write_reg(REG_STEER_DUTY_RIGHT, CFG_DATA_W'(right));
		write_reg(REG_NEUTRAL_DUTY, CFG_DATA_W'(neu));
		write_reg(REG_REVERSE_DUTY, CFG_DATA_W'(rev));
		write_reg(REG_ARM_TIMEOUT, CFG_DATA_W'(tmo));
		cfg_ch.valid <= 1'b0;
	endtask

	// neutral and threshold taken from the speed map so every branch is reachable
	task automatic random_config();
		int lo, hi, neu, rev;
		lo  = $urandom_range(0, 10000);
		hi  = $urandom_range(0, 10000);
		neu = int'(sb.map_duty($urandom_range(0, 200) - 100, SPEED_LIMIT_DEF,
			DUTY_W'(lo), DUTY_W'(hi)));
		rev = int'(sb.map_duty($urandom_range(0, 200) - 100, SPEED_LIMIT_DEF,
			DUTY_W'(lo), DUTY_W'(hi)));
		load_config(lo, hi, $urandom_range(0, 10000), $urandom_range(0, 10000), neu, rev,
			$urandom_range(0, 65535));
	endtask

	function automatic drive_word_t random_word();
		drive_word_t w;
		int r;
		w.action = ($urandom_range(0, 99) < 40) ? ACT_TICK : ACT_DRIVE;
		w.speed_cmd = ($urandom_range(0, 99) < 85) ? CMD_W'($urandom_range(0, 200) - 100)
			: CMD_W'($urandom);
		w.steer_cmd = ($urandom_range(0, 99) < 85) ? CMD_W'($urandom_range(0, 400) - 200)
			: CMD_W'($urandom);
		r = $urandom_range(0, 99);
		if (r < 70)
			w.elapsed_ms = MS_W'($urandom_range(0, 50));
		else if (r < 90)
			w.elapsed_ms = MS_W'($urandom_range(0, 5000));
		else
			w.elapsed_ms = MS_W'($urandom);
		return w;
	endfunction

	task automatic random_phase(input bit long_hold);
		for (int n = 0; n < PHASE_WORDS; n++) begin
			if (n % 50 == 0)
				quiet = ($urandom_range(0, 2) == 0);
			if (long_hold && n == 20)
				hold_req = 1'b1;
			send_word(random_word());
		end
		drain();
	endtask

	initial begin
		item_ch.valid      <= 1'b0;
		item_ch.action     <= ACT_DRIVE;
		item_ch.speed_cmd  <= '0;
		item_ch.steer_cmd  <= '0;
		item_ch.elapsed_ms <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= '0;
		cfg_ch.data        <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// commands at and beyond the limits, before any tick
		send_drive(0, 0);
		send_drive(100, 200);
		send_drive(-100, -200);
		send_drive(101, 0);
		send_drive(-101, 0);
		send_drive(0, 201);
		send_drive(0, -201);
		send_drive(2047, -2048);
		send_drive(-2048, 2047);
		drain();

		// zero timeout: armed already on the first tick
		write_reg(REG_ARM_TIMEOUT, 16'd0);
		cfg_ch.valid <= 1'b0;
		send_tick(65535);
		drain();

		load_config(SPEED_DUTY_LOW_RST, SPEED_DUTY_HIGH_RST, STEER_DUTY_LEFT_RST,
			STEER_DUTY_RIGHT_RST, NEUTRAL_DUTY_RST, REVERSE_DUTY_RST, ARM_TIMEOUT_RST);
		send_drive(100, -17);
		send_tick(1000);
		send_tick(1999);
		send_tick(1);
		send_drive(0, 33);
		send_tick(0);
		send_tick(0);
		send_drive(52, 0);
		send_tick(7);
		send_drive(100, 200);
		send_tick(7);
		send_drive(-100, -200);
		send_tick(7);
		send_drive(101, 5);
		send_tick(65535);
		drain();

		load_config(0, 0, 0, 0, 0, 0, 0);
		random_phase(1'b0);
		load_config(10000, 10000, 10000, 10000, 10000, 10000, 65535);
		random_phase(1'b1);
		load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		write_reg(REG_UNUSED, 16'h1234);
		cfg_ch.valid <= 1'b0;
		random_phase(1'b0);
		load_config(0, 10000, 10000, 0, 5000, 4000, 100);
		random_phase(1'b0);
		random_config();
		random_phase(1'b0);
		random_config();
		random_phase(1'b1);
		idle_on = 1'b0;
		random_config();
		random_phase(1'b0);

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hdl/etsp_pkg.sv
hdl/etsp_if.sv
hdl/etsp_map_lane.sv
hdl/esc_throttle_steer_pwm_sequencer.sv
sim/tb_esc_throttle_steer_pwm_sequencer.sv
